// File: rtl/sqd_pkg.sv
package sqd_pkg;
    localparam int NUM_QUEUES_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 16;
    localparam int CFG_W           = 3;
    localparam int SVC_W           = 8;
    localparam int QIDX_W          = 2;
    localparam int QLEN_W          = 5;
    localparam int MASK_W          = 4;
    localparam int CNT_W           = 3;
    localparam int CTIME_W         = 16;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 3'd4;
    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_ARRIVAL  = 1'b1;
endpackage

// File: rtl/sqd_job_ram.sv
module sqd_job_ram
    import sqd_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [SVC_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [SVC_W-1:0] rdata
);
    logic [SVC_W-1:0] mem [DEPTH];
    logic [SVC_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/shortest_queue_dispatcher_core.sv
// Join-shortest-queue dispatcher core.
// Input channel (in_valid/in_stall) carries kind and service_time. A tick
// (kind 0) advances the time counter; each active nonempty queue whose
// deadline equals the new time completes its head job. An arrival (kind 1)
// joins the shortest active queue, lowest index on ties; a full queue rejects.
// Every input transfer produces exactly one output transfer.
// Job service times live in a single-port-read synchronous RAM (registered
// read data). Lengths, pointers and deadlines are flip-flops.
// An arrival's result is written to the output register at its transfer.
// A tick passes through ST_SCAN, then one ST_READ/ST_SCAN round for each
// completing queue that still holds a job (one RAM read of its new head),
// then ST_DONE, which loads the output register once it is free or leaving.
// One item is in work at a time; the next transfer is taken once the
// result is in the output register and that register is free or leaving.
// Reset (rst_n low, async) clears time, lengths, pointers, deadlines and
// sets active_queues to 4; the RAM needs no clearing because only held
// entries are ever read. A stalled output holds its fields stable and
// blocks new input transfers until it is taken.
module shortest_queue_dispatcher_core
    import sqd_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [SVC_W-1:0]   service_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic [QIDX_W-1:0]  queue_index,
    output logic [QLEN_W-1:0]  queue_length,
    output logic               rejected,
    output logic [MASK_W-1:0]  completed_mask,
    output logic [CNT_W-1:0]   completed_count,
    output logic [CTIME_W-1:0] current_time
);
    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int LW  = $clog2(QUEUE_DEPTH + 1);
    localparam int AW  = QW + PW;
    localparam int NW  = $clog2(NUM_QUEUES + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_READ, ST_DONE} state_t;

    // ring pointer step, wraps at QUEUE_DEPTH
    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        if (32'(p) == QUEUE_DEPTH - 1)
            return '0;
        return p + PW'(1);
    endfunction

    state_t                 state_reg;
    logic [CFG_W-1:0]       active_reg;
    logic [TIME_BITS-1:0]   time_reg;
    logic [LW-1:0]          fill_reg     [NUM_QUEUES];
    logic [TIME_BITS-1:0]   deadline_reg [NUM_QUEUES];
    logic [PW-1:0]          head_reg     [NUM_QUEUES];
    logic [PW-1:0]          tail_reg     [NUM_QUEUES];
    logic [NUM_QUEUES-1:0]  pend_reg;     // queues still needing a new head read
    logic [NUM_QUEUES-1:0]  mask_reg;
    logic [QW-1:0]          rq_reg;       // queue whose head is being read

    logic                   ov_reg;
    logic                   okind_reg;
    logic [QIDX_W-1:0]      oidx_reg;
    logic [QLEN_W-1:0]      olen_reg;
    logic                   orej_reg;
    logic [MASK_W-1:0]      omask_reg;
    logic [CNT_W-1:0]       ocnt_reg;
    logic [CTIME_W-1:0]     otime_reg;

    // active count clamped to 1..NUM_QUEUES
    logic [NW-1:0] live;
    always_comb
    begin
        if (active_reg == '0)
            live = NW'(1);
        else if (32'(active_reg) > NUM_QUEUES)
            live = NW'(NUM_QUEUES);
        else
            live = NW'(active_reg);
    end

    logic out_free;
    logic take;
    logic out_load;
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = !(state_reg == ST_IDLE && out_free);
    assign take     = in_valid && !in_stall;
    // output register loads an arrival result or a finished tick result
    assign out_load = (take && kind == KIND_ARRIVAL) || (state_reg == ST_DONE && out_free);

    // shortest queue search: NUM_QUEUES is to be kept at most 8; the block does not enforce it
    logic [QW-1:0] best;
    logic [LW-1:0] best_len;
    always_comb
    begin
        best     = '0;
        best_len = fill_reg[0];
        for (int q = 1; q < NUM_QUEUES; q++)
        begin
            if (q < 32'(live) && fill_reg[q] < best_len)
            begin
                best     = QW'(q);
                best_len = fill_reg[q];
            end
        end
    end

    logic [TIME_BITS-1:0] time_inc;
    logic [NUM_QUEUES-1:0] hit;
    assign time_inc = time_reg + TIME_BITS'(1);
    always_comb
    begin
        for (int q = 0; q < NUM_QUEUES; q++)
            hit[q] = (q < 32'(live)) && (fill_reg[q] != '0) && (deadline_reg[q] == time_inc);
    end

    // lowest pending queue after a completion (pend bits only for fill left > 0)
    logic [QW-1:0] pick;
    logic          pick_any;
    always_comb
    begin
        pick     = '0;
        pick_any = 1'b0;
        for (int q = NUM_QUEUES - 1; q >= 0; q--)
        begin
            if (pend_reg[q])
            begin
                pick     = QW'(q);
                pick_any = 1'b1;
            end
        end
    end

    logic [SVC_W-1:0] svc;
    assign svc = (service_time == '0) ? SVC_W'(1) : service_time;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [SVC_W-1:0] ram_rdata;
    logic             do_store;

    assign do_store  = take && kind == KIND_ARRIVAL && 32'(best_len) < QUEUE_DEPTH;
    assign ram_we    = do_store;
    assign ram_waddr = {best, tail_reg[best]};
    assign ram_re    = (state_reg == ST_SCAN) && pick_any;
    assign ram_raddr = {pick, head_reg[pick]};

    sqd_job_ram #(.DEPTH(1 << AW), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (svc),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [CNT_W-1:0] mask_cnt;
    always_comb
    begin
        mask_cnt = '0;
        for (int q = 0; q < NUM_QUEUES; q++)
            mask_cnt = mask_cnt + CNT_W'(mask_reg[q]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= ACTIVE_RESET;
            time_reg   <= '0;
            pend_reg   <= '0;
            mask_reg   <= '0;
            rq_reg     <= '0;
            ov_reg     <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                fill_reg[q]     <= '0;
                deadline_reg[q] <= '0;
                head_reg[q]     <= '0;
                tail_reg[q]     <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                active_reg <= cfg_wdata;
            if (out_load)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (take && kind == KIND_ARRIVAL)
                    begin
                        if (do_store)
                        begin
                            tail_reg[best] <= ptr_inc(tail_reg[best]);
                            fill_reg[best] <= best_len + LW'(1);
                            if (best_len == '0)
                                deadline_reg[best] <= time_reg + TIME_BITS'(svc);
                        end
                        okind_reg <= KIND_ARRIVAL;
                        oidx_reg  <= QIDX_W'(best);
                        olen_reg  <= do_store ? QLEN_W'(best_len + LW'(1)) : QLEN_W'(best_len);
                        orej_reg  <= !do_store;
                        omask_reg <= '0;
                        ocnt_reg  <= '0;
                        otime_reg <= CTIME_W'(time_reg);
                    end
                    else if (take)
                    begin
                        time_reg <= time_inc;
                        for (int q = 0; q < NUM_QUEUES; q++)
                        begin
                            if (hit[q])
                            begin
                                head_reg[q] <= ptr_inc(head_reg[q]);
                                fill_reg[q] <= fill_reg[q] - LW'(1);
                                pend_reg[q] <= (fill_reg[q] != LW'(1));
                            end
                            else
                            begin
                                pend_reg[q] <= 1'b0;
                            end
                        end
                        mask_reg  <= hit;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (pick_any)
                    begin
                        rq_reg         <= pick;
                        pend_reg[pick] <= 1'b0;
                        state_reg      <= ST_READ;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_READ:
                begin
                    deadline_reg[rq_reg] <= time_reg + TIME_BITS'(ram_rdata);
                    state_reg            <= ST_SCAN;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        okind_reg <= KIND_TICK;
                        oidx_reg  <= '0;
                        olen_reg  <= '0;
                        orej_reg  <= 1'b0;
                        omask_reg <= MASK_W'(mask_reg);
                        ocnt_reg  <= mask_cnt;
                        otime_reg <= CTIME_W'(time_reg);
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = ov_reg;
    assign result_kind     = okind_reg;
    assign queue_index     = oidx_reg;
    assign queue_length    = olen_reg;
    assign rejected        = orej_reg;
    assign completed_mask  = omask_reg;
    assign completed_count = ocnt_reg;
    assign current_time    = otime_reg;
endmodule

// File: tb/shortest_queue_dispatcher_core_tb.sv
module shortest_queue_dispatcher_core_tb;
    import sqd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ          = NUM_QUEUES_DEF;
    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int IDLE_LIMIT  = 5000;
    // worst tick: one head read per completing queue, plus margin
    localparam int DRAIN_WAIT  = 2 + 2 * NQ + 8;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic                kind;
        logic [QIDX_W-1:0]   qidx;
        logic [QLEN_W-1:0]   qlen;
        logic                rej;
        logic [MASK_W-1:0]   mask;
        logic [CNT_W-1:0]    cnt;
        logic [CTIME_W-1:0]  ctime;
    } dispatch_t;

    typedef struct packed {
        logic              kind;
        logic [SVC_W-1:0]  svc;
        logic              typed;  // expected written out by hand
        dispatch_t         want;
    } job_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               kind = KIND_TICK;
    logic [SVC_W-1:0]   service_time = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               result_kind;
    logic [QIDX_W-1:0]  queue_index;
    logic [QLEN_W-1:0]  queue_length;
    logic               rejected;
    logic [MASK_W-1:0]  completed_mask;
    logic [CNT_W-1:0]   completed_count;
    logic [CTIME_W-1:0] current_time;

    shortest_queue_dispatcher_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .service_time    (service_time),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .queue_index     (queue_index),
        .queue_length    (queue_length),
        .rejected        (rejected),
        .completed_mask  (completed_mask),
        .completed_count (completed_count),
        .current_time    (current_time)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the dispatcher state
    logic [CTIME_W-1:0] clock_now;
    logic [SVC_W-1:0]   job_mem [NQ][DEPTH];
    int unsigned        depth_of [NQ];
    logic [CTIME_W-1:0] due_at [NQ];
    int unsigned        rd_ptr [NQ];
    int unsigned        wr_ptr [NQ];
    logic [CFG_W-1:0]   live_setting;

    dispatch_t pending_results [$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        stall_quiet = 1'b0;  // no output stalls in this stretch
    bit        gaps_off = 1'b0;     // sender runs back to back

    function automatic int unsigned queues_in_use();
        if (live_setting == 0)
            return 1;
        if (live_setting > NQ)
            return NQ;
        return live_setting;
    endfunction

    // Advance the shadow state by one transfer and return its result
    function automatic dispatch_t dispatch_step(logic k, logic [SVC_W-1:0] svc);
        dispatch_t   r;
        int unsigned n;
        int unsigned best;
        logic [SVC_W-1:0] st;
        n = queues_in_use();
        r = '0;
        r.kind = k;
        if (k == KIND_TICK)
        begin
            clock_now = clock_now + 1'b1;
            for (int q = 0; q < n; q++)
            begin
                if (depth_of[q] != 0 && due_at[q] == clock_now)
                begin
                    rd_ptr[q] = (rd_ptr[q] + 1) % DEPTH;
                    depth_of[q]--;
                    if (depth_of[q] != 0)
                        due_at[q] = clock_now + job_mem[q][rd_ptr[q]];
                    r.mask[q] = 1'b1;
                    r.cnt++;
                end
            end
        end
        else
        begin
            st = (svc == 0) ? 8'd1 : svc;
            best = 0;
            for (int q = 1; q < n; q++)
                if (depth_of[q] < depth_of[best])
                    best = q;
            if (depth_of[best] >= DEPTH)
                r.rej = 1'b1;
            else
            begin
                job_mem[best][wr_ptr[best]] = st;
                wr_ptr[best] = (wr_ptr[best] + 1) % DEPTH;
                depth_of[best]++;
                if (depth_of[best] == 1)
                    due_at[best] = clock_now + st;
            end
            r.qidx = QIDX_W'(best);
            r.qlen = QLEN_W'(depth_of[best]);
        end
        r.ctime = clock_now;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (gaps_off)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One input transfer; valid stays up if no gap follows
    task automatic send_job(logic k, logic [SVC_W-1:0] svc, bit typed, dispatch_t want);
        dispatch_t   predicted;
        int unsigned gap;
        in_valid     <= 1'b1;
        kind         <= k;
        service_time <= svc;
        do
            @(posedge clk);
        while (in_stall);
        predicted = dispatch_step(k, svc);
        pending_results.push_back(typed ? want : predicted);
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Register write only when nothing is in flight
    task automatic set_active(logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        live_setting = value;
    endtask

    // Random arrival/tick mix; arrival_pct high fills queues up to rejection
    task automatic random_burst(int count, int arrival_pct);
        logic [SVC_W-1:0] svc;
        logic             k;
        for (int i = 0; i < count; i++)
        begin
            k = ($urandom_range(0, 99) < arrival_pct) ? KIND_ARRIVAL : KIND_TICK;
            if ($urandom_range(0, 3) == 0)
                svc = SVC_W'($urandom_range(0, 255));
            else
                svc = SVC_W'($urandom_range(0, 6));
            send_job(k, svc, 1'b0, '0);
        end
    endtask

    // Output side: random stalls, checks every transfer against the oldest expectation
    int unsigned stall_left = 0;
    always @(posedge clk)
    begin
        dispatch_t got;
        dispatch_t want;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{result_kind, queue_index, queue_length, rejected,
                        completed_mask, completed_count, current_time};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.qidx !== want.qidx
                        || got.qlen !== want.qlen || got.rej !== want.rej
                        || got.mask !== want.mask || got.cnt !== want.cnt
                        || got.ctime !== want.ctime)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (stall_quiet)
            begin
                out_stall  <= 1'b0;
                stall_left <= 0;
            end
            else if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 99) < 4)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
            else
                out_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    // Directed rows: fresh reset state, four queues
    job_row_t opening [14];
    logic [CFG_W-1:0] settings [10] = '{3'd4, 3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6,
                                        3'd4, 3'd1};

    initial
    begin
        clock_now    = '0;
        live_setting = ACTIVE_RESET;
        for (int q = 0; q < NQ; q++)
        begin
            depth_of[q] = 0;
            due_at[q]   = '0;
            rd_ptr[q]   = 0;
            wr_ptr[q]   = 0;
        end

        opening[0]  = '{KIND_TICK,    8'd0,   1'b1, '{KIND_TICK, 2'd0, 5'd0, 1'b0, 4'd0, 3'd0, 16'd1}};
        opening[1]  = '{KIND_ARRIVAL, 8'd255, 1'b1, '{KIND_ARRIVAL, 2'd0, 5'd1, 1'b0, 4'd0, 3'd0, 16'd1}};
        // zero service time runs as one tick
        opening[2]  = '{KIND_ARRIVAL, 8'd0,   1'b0, '0};
        opening[3]  = '{KIND_ARRIVAL, 8'd1,   1'b0, '0};
        opening[4]  = '{KIND_ARRIVAL, 8'd128, 1'b0, '0};
        opening[5]  = '{KIND_ARRIVAL, 8'd2,   1'b0, '0};
        // queues 1 and 2 finish together
        opening[6]  = '{KIND_TICK,    8'hFF,  1'b0, '0};
        opening[7]  = '{KIND_TICK,    8'd0,   1'b0, '0};
        opening[8]  = '{KIND_ARRIVAL, 8'hAA,  1'b0, '0};
        opening[9]  = '{KIND_ARRIVAL, 8'h55,  1'b0, '0};
        opening[10] = '{KIND_TICK,    8'd0,   1'b0, '0};
        opening[11] = '{KIND_TICK,    8'd0,   1'b0, '0};
        opening[12] = '{KIND_ARRIVAL, 8'd1,   1'b0, '0};
        opening[13] = '{KIND_TICK,    8'd0,   1'b0, '0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_job(opening[i].kind, opening[i].svc, opening[i].typed, opening[i].want);

        // Sweep the register, extremes included; arrival-heavy phases hit rejection
        foreach (settings[p])
        begin
            set_active(settings[p]);
            stall_quiet = (p == 3);
            gaps_off    = (p == 3);
            random_burst(140, (p % 3 == 1) ? 85 : ((p % 3 == 2) ? 35 : 55));
        end

        // Long jobs back to back, then a random tail
        set_active(3'd4);
        stall_quiet = 1'b1;
        gaps_off    = 1'b1;
        for (int i = 0; i < 8; i++)
            send_job(KIND_ARRIVAL, 8'd255, 1'b0, '0);
        stall_quiet = 1'b0;
        gaps_off    = 1'b0;
        random_burst(60, 60);

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
